FILE: rtl/core/sdr_pkg.sv
// Package for the staged descent reference ramp.
// Holds the shared types, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package sdr_pkg;

   localparam int unsigned HEIGHT_W = 16;
   localparam int unsigned RATE_W   = 14;
   localparam int unsigned DT_W     = 12;
   localparam int unsigned PHASE_W  = 3;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned DATA_W   = 32;

   // Time step is in 1/1024 second units.
   localparam int unsigned FRAC_W   = 10;
   localparam int unsigned PROD_W   = RATE_W + DT_W;
   localparam int unsigned STEP_W   = PROD_W + 1 - FRAC_W;

   localparam logic [HEIGHT_W-1:0] TEST_HEIGHT_RST        = 16'd500;
   localparam logic [HEIGHT_W-1:0] FAST_BAND_HEIGHT_RST   = 16'd5000;
   localparam logic [HEIGHT_W-1:0] SLOW_BAND_HEIGHT_RST   = 16'd2000;
   localparam logic [RATE_W-1:0]   FAST_RATE_RST          = 14'd1000;
   localparam logic [RATE_W-1:0]   MEDIUM_RATE_RST        = 14'd500;
   localparam logic [RATE_W-1:0]   SLOW_RATE_RST          = 14'd200;
   localparam logic [HEIGHT_W-1:0] RECOVERY_HEIGHT_RST    = 16'd3000;
   localparam logic [HEIGHT_W-1:0] MAX_TRACKING_ERROR_RST = 16'd1000;

   typedef enum logic [PHASE_W-1:0] {
      PH_WAITING    = 3'd0,
      PH_DESCENDING = 3'd1,
      PH_RECOVERING = 3'd2,
      PH_PAUSED     = 3'd3,
      PH_HOLD       = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      REG_TEST_HEIGHT        = 3'd0,
      REG_FAST_BAND_HEIGHT   = 3'd1,
      REG_SLOW_BAND_HEIGHT   = 3'd2,
      REG_FAST_RATE          = 3'd3,
      REG_MEDIUM_RATE        = 3'd4,
      REG_SLOW_RATE          = 3'd5,
      REG_RECOVERY_HEIGHT    = 3'd6,
      REG_MAX_TRACKING_ERROR = 3'd7
   } reg_index_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] test_height;
      logic [HEIGHT_W-1:0] fast_band_height;
      logic [HEIGHT_W-1:0] slow_band_height;
      logic [RATE_W-1:0]   fast_rate;
      logic [RATE_W-1:0]   medium_rate;
      logic [RATE_W-1:0]   slow_rate;
      logic [HEIGHT_W-1:0] recovery_height;
      logic [HEIGHT_W-1:0] max_tracking_error;
   } cfg_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] reference_height;
      logic                seeded;
      logic                descent_begun;
   } state_type;

   typedef struct packed {
      logic                operation;
      logic                reference_valid;
      logic [HEIGHT_W-1:0] measured_height;
      logic [DT_W-1:0]     time_step;
      logic                climb_demand;
      logic                descent_allowed;
   } req_item_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height_reference;
      phase_type           phase;
      logic                ref_moved;
      logic                at_test_floor;
   } rsp_item_type;

endpackage

FILE: rtl/core/staged_descent_reference_ramp.sv
// Top level of the staged descent reference ramp: input register, step logic,
// result register and configuration registers.
// Throughput: one transaction per cycle while the result register is not stalled,
// set by the single-pass step logic and the one rate multiplier between the input
// and result registers.
// Reset clears the reference state and both stages and restores register defaults.
`timescale 1ns / 1ps

module staged_descent_reference_ramp #(
   parameter int unsigned RECOVERY_RATE = 500
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic                          req_reference_valid,
   input  logic [15:0]                   req_measured_height,
   input  logic [11:0]                   req_time_step,
   input  logic                          req_climb_demand,
   input  logic                          req_descent_allowed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_height_reference,
   output logic [2:0]                    rsp_phase,
   output logic                          rsp_ref_moved,
   output logic                          rsp_at_test_floor,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sdr_pkg::ADDR_W-1:0]    paddr,
   input  logic [sdr_pkg::DATA_W-1:0]    pwdata,
   output logic [sdr_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   sdr_pkg::cfg_type       cfg;
   sdr_pkg::state_type     state_ff;
   sdr_pkg::state_type     state_in;
   sdr_pkg::state_type     state_next;
   sdr_pkg::req_item_type  item_ff;
   sdr_pkg::req_item_type  item_in;
   sdr_pkg::rsp_item_type  result;
   sdr_pkg::rsp_item_type  rsp_ff;
   sdr_pkg::rsp_item_type  rsp_in;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   emit;
   logic                   out_free;
   logic                   advance;
   logic                   accept;

   sdr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdr_calc u_calc (
      .cfg           (cfg),
      .state         (state_ff),
      .item          (item_ff),
      .recovery_rate (sdr_pkg::RATE_W'(RECOVERY_RATE)),
      .state_next    (state_next),
      .emit          (emit),
      .result        (result)
   );

   // The input stage moves on whenever the result register is empty or being taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in.operation       = req_operation;
      item_in.reference_valid = req_reference_valid;
      item_in.measured_height = req_measured_height;
      item_in.time_step       = req_time_step;
      item_in.climb_demand    = req_climb_demand;
      item_in.descent_allowed = req_descent_allowed;

      s1_valid_in = req_stall ? s1_valid_ff : req_valid;
      state_in    = advance ? state_next : state_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = advance && emit;
         if (advance && emit) begin
            rsp_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_height_reference = rsp_ff.height_reference;
   assign rsp_phase            = rsp_ff.phase;
   assign rsp_ref_moved        = rsp_ff.ref_moved;
   assign rsp_at_test_floor    = rsp_ff.at_test_floor;

endmodule

FILE: rtl/core/sdr_csr.sv
// Configuration register file of the staged descent reference ramp.
// APB-style write and read access to the eight tuning registers.
// Depends on sdr_pkg.
`timescale 1ns / 1ps

module sdr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sdr_pkg::ADDR_W-1:0]  paddr,
   input  logic [sdr_pkg::DATA_W-1:0]  pwdata,
   output logic [sdr_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output sdr_pkg::cfg_type            cfg
);

   sdr_pkg::cfg_type       cfg_ff;
   sdr_pkg::cfg_type       cfg_in;
   sdr_pkg::reg_index_type index;
   logic                   wr_en;

   assign pready = 1'b1;
   assign index  = sdr_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            sdr_pkg::REG_TEST_HEIGHT:        cfg_in.test_height        = pwdata[15:0];
            sdr_pkg::REG_FAST_BAND_HEIGHT:   cfg_in.fast_band_height   = pwdata[15:0];
            sdr_pkg::REG_SLOW_BAND_HEIGHT:   cfg_in.slow_band_height   = pwdata[15:0];
            sdr_pkg::REG_FAST_RATE:          cfg_in.fast_rate          = pwdata[13:0];
            sdr_pkg::REG_MEDIUM_RATE:        cfg_in.medium_rate        = pwdata[13:0];
            sdr_pkg::REG_SLOW_RATE:          cfg_in.slow_rate          = pwdata[13:0];
            sdr_pkg::REG_RECOVERY_HEIGHT:    cfg_in.recovery_height    = pwdata[15:0];
            sdr_pkg::REG_MAX_TRACKING_ERROR: cfg_in.max_tracking_error = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.test_height        <= sdr_pkg::TEST_HEIGHT_RST;
         cfg_ff.fast_band_height   <= sdr_pkg::FAST_BAND_HEIGHT_RST;
         cfg_ff.slow_band_height   <= sdr_pkg::SLOW_BAND_HEIGHT_RST;
         cfg_ff.fast_rate          <= sdr_pkg::FAST_RATE_RST;
         cfg_ff.medium_rate        <= sdr_pkg::MEDIUM_RATE_RST;
         cfg_ff.slow_rate          <= sdr_pkg::SLOW_RATE_RST;
         cfg_ff.recovery_height    <= sdr_pkg::RECOVERY_HEIGHT_RST;
         cfg_ff.max_tracking_error <= sdr_pkg::MAX_TRACKING_ERROR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (index)
         sdr_pkg::REG_TEST_HEIGHT:        prdata = 32'(cfg_ff.test_height);
         sdr_pkg::REG_FAST_BAND_HEIGHT:   prdata = 32'(cfg_ff.fast_band_height);
         sdr_pkg::REG_SLOW_BAND_HEIGHT:   prdata = 32'(cfg_ff.slow_band_height);
         sdr_pkg::REG_FAST_RATE:          prdata = 32'(cfg_ff.fast_rate);
         sdr_pkg::REG_MEDIUM_RATE:        prdata = 32'(cfg_ff.medium_rate);
         sdr_pkg::REG_SLOW_RATE:          prdata = 32'(cfg_ff.slow_rate);
         sdr_pkg::REG_RECOVERY_HEIGHT:    prdata = 32'(cfg_ff.recovery_height);
         sdr_pkg::REG_MAX_TRACKING_ERROR: prdata = 32'(cfg_ff.max_tracking_error);
         default:                         prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/sdr_calc.sv
// Single-pass step logic of the staged descent reference ramp.
// Computes the next reference state and the result of one transaction.
// Depends on sdr_pkg.
`timescale 1ns / 1ps

module sdr_calc (
   input  sdr_pkg::cfg_type               cfg,
   input  sdr_pkg::state_type             state,
   input  sdr_pkg::req_item_type          item,
   input  logic [sdr_pkg::RATE_W-1:0]     recovery_rate,
   output sdr_pkg::state_type             state_next,
   output logic                           emit,
   output sdr_pkg::rsp_item_type          result
);

   logic [sdr_pkg::HEIGHT_W-1:0] ref_h;
   logic [sdr_pkg::HEIGHT_W-1:0] ref_new;
   logic [sdr_pkg::HEIGHT_W-1:0] climb_gap;
   logic [sdr_pkg::HEIGHT_W-1:0] descend_gap;
   logic [sdr_pkg::HEIGHT_W-1:0] track_err;
   logic [sdr_pkg::RATE_W-1:0]   band_rate;
   logic [sdr_pkg::RATE_W-1:0]   rate_sel;
   logic [sdr_pkg::PROD_W-1:0]   product;
   logic [sdr_pkg::PROD_W:0]     rounded;
   logic [sdr_pkg::STEP_W-1:0]   step;
   sdr_pkg::phase_type           phase;
   logic                         accepted;

   assign ref_h = state.reference_height;

   always_comb begin
      if (ref_h > cfg.fast_band_height) begin
         band_rate = cfg.fast_rate;
      end else if (ref_h > cfg.slow_band_height) begin
         band_rate = cfg.medium_rate;
      end else begin
         band_rate = cfg.slow_rate;
      end
   end

   // One shared multiplier serves both the climb and the descent.
   assign rate_sel    = item.climb_demand ? recovery_rate : band_rate;
   assign product     = sdr_pkg::PROD_W'(rate_sel) * sdr_pkg::PROD_W'(item.time_step);
   assign rounded     = {1'b0, product} + (sdr_pkg::PROD_W+1)'(1 << (sdr_pkg::FRAC_W - 1));
   assign step        = rounded[sdr_pkg::PROD_W:sdr_pkg::FRAC_W];
   assign climb_gap   = cfg.recovery_height - ref_h;
   assign descend_gap = ref_h - cfg.test_height;
   assign track_err   = (item.measured_height > ref_h) ? (item.measured_height - ref_h)
                                                       : (ref_h - item.measured_height);
   assign accepted    = (item.reference_valid == 1'b1) && (item.time_step != '0);

   always_comb begin
      state_next = state;
      ref_new    = ref_h;
      phase      = sdr_pkg::PH_WAITING;
      emit       = 1'b0;
      if (item.operation == sdr_pkg::OP_CLEAR) begin
         state_next = '0;
      end else if (accepted) begin
         emit = 1'b1;
         if (!state.seeded) begin
            ref_new = (item.measured_height > cfg.test_height) ? item.measured_height
                                                                : cfg.test_height;
            state_next.seeded = 1'b1;
            if (item.climb_demand) begin
               phase = sdr_pkg::PH_RECOVERING;
            end else if (item.descent_allowed) begin
               phase = sdr_pkg::PH_DESCENDING;
            end else begin
               phase = sdr_pkg::PH_WAITING;
            end
         end else if (item.climb_demand) begin
            if (ref_h < cfg.recovery_height) begin
               ref_new = (step >= sdr_pkg::STEP_W'(climb_gap)) ? cfg.recovery_height
                         : ref_h + step[sdr_pkg::HEIGHT_W-1:0];
               state_next.descent_begun = 1'b1;
               phase = sdr_pkg::PH_RECOVERING;
            end else begin
               phase = sdr_pkg::PH_PAUSED;
            end
         end else if (!item.descent_allowed) begin
            phase = state.descent_begun ? sdr_pkg::PH_PAUSED : sdr_pkg::PH_WAITING;
         end else if (ref_h <= cfg.test_height) begin
            ref_new = cfg.test_height;
            phase   = sdr_pkg::PH_HOLD;
         end else if (track_err > cfg.max_tracking_error) begin
            phase = sdr_pkg::PH_PAUSED;
         end else begin
            ref_new = (step >= sdr_pkg::STEP_W'(descend_gap)) ? cfg.test_height
                      : ref_h - step[sdr_pkg::HEIGHT_W-1:0];
            state_next.descent_begun = 1'b1;
            phase = (ref_new <= cfg.test_height) ? sdr_pkg::PH_HOLD : sdr_pkg::PH_DESCENDING;
         end
         state_next.reference_height = ref_new;
      end
   end

   // A seeding transaction never reports the reference as moved.
   assign result.height_reference = ref_new;
   assign result.phase            = phase;
   assign result.ref_moved        = state.seeded && (ref_new != ref_h);
   assign result.at_test_floor    = (ref_new <= cfg.test_height);

endmodule

FILE: rtl/core/sdr_checker.sv
// Port-level checker for the staged descent reference ramp.
// Bound to the top level; depends on sdr_pkg for the phase codes.
`timescale 1ns / 1ps

module sdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_height_reference,
   input logic [2:0]  rsp_phase,
   input logic        rsp_ref_moved,
   input logic        rsp_at_test_floor
);

   // Both stages come out of reset empty.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid && rsp_stall) |->
         rsp_valid && $stable(rsp_height_reference) && $stable(rsp_phase)
         && $stable(rsp_ref_moved) && $stable(rsp_at_test_floor))
      else $error("stalled result changed");

   // Waiting and paused steps never move the reference.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == sdr_pkg::PH_PAUSED || rsp_phase == sdr_pkg::PH_WAITING)
         |-> !rsp_ref_moved)
      else $error("reference moved while waiting or paused");

   // Holding at the test height always reports the test height as reached.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == sdr_pkg::PH_HOLD |-> rsp_at_test_floor)
      else $error("hold phase without test height reached");

endmodule

bind staged_descent_reference_ramp sdr_checker u_sdr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_height_reference (rsp_height_reference),
   .rsp_phase            (rsp_phase),
   .rsp_ref_moved        (rsp_ref_moved),
   .rsp_at_test_floor    (rsp_at_test_floor)
);
